>>> rtl/core/lzss_token_stream_checker_unit_defines.svh
// Assertion macros for the LZSS token stream checker.
`ifndef LZSS_TOKEN_STREAM_CHECKER_UNIT_DEFINES_SVH
`define LZSS_TOKEN_STREAM_CHECKER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define LTSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ltsc assertion failed");
`define LTSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ltsc assertion failed");
`else
`define LTSC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LTSC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/core/ltsc_pkg.sv
package ltsc_pkg;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_WINDOW   = 4'd1,
    ST_RANGE    = 4'd2,
    ST_FLAGS    = 4'd3,
    ST_LIMIT    = 4'd4,
    ST_TAG      = 4'd5,
    ST_TRUNC    = 4'd6,
    ST_DIST     = 4'd7,
    ST_LEN      = 4'd8,
    ST_OVF      = 4'd9,
    ST_MISMATCH = 4'd10
  } status_t;

  typedef enum logic [2:0] {
    REG_MAX_DIST       = 3'd0,
    REG_MIN_MATCH      = 3'd1,
    REG_MAX_MATCH      = 3'd2,
    REG_FORMAT_FLAGS   = 3'd3,
    REG_FRAME_SIZE     = 3'd4,
    REG_LIMIT_DISTANCE = 3'd5,
    REG_LIMIT_MATCH    = 3'd6,
    REG_LIMIT_FRAME    = 3'd7
  } cfg_idx_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [31:0] RST_MAX_DIST       = 32'd4096;
  localparam logic [31:0] RST_MIN_MATCH      = 32'd5;
  localparam logic [31:0] RST_MAX_MATCH      = 32'd258;
  localparam logic [31:0] RST_FORMAT_FLAGS   = 32'd0;
  localparam logic [63:0] RST_FRAME_SIZE     = 64'd0;
  localparam logic [31:0] RST_LIMIT_DISTANCE = 32'hFFFF_FFFF;
  localparam logic [31:0] RST_LIMIT_MATCH    = 32'hFFFF_FFFF;
  localparam logic [63:0] RST_LIMIT_FRAME    = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [31:0] MIN_MATCH_FLOOR = 32'd5;

  localparam logic [7:0] TAG_MATCH  = 8'd1;
  localparam logic       KIND_LIT   = 1'b0;
  localparam logic       KIND_MATCH = 1'b1;

  localparam logic [3:0] POS_IDLE   = 4'd0;
  localparam logic [3:0] POS_FIRST  = 4'd1;
  localparam logic [3:0] LIT_LAST   = 4'd1;
  localparam logic [3:0] DIST_LAST  = 4'd4;
  localparam logic [3:0] MATCH_LAST = 4'd8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic        token_kind;
    logic [7:0]  literal_byte;
    logic [31:0] match_distance;
    logic [31:0] match_length;
    status_t     status;
    logic [63:0] produced_total;
  } out_item_t;

  typedef struct packed {
    logic [31:0] max_dist;
    logic [31:0] min_match;
    logic [31:0] max_match;
    logic [31:0] limit_match;
    logic [63:0] frame_size;
    status_t     param_status;
    logic        frame_over;
  } chk_cfg_t;

endpackage

>>> rtl/core/ltsc_cfg.sv
module ltsc_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ltsc_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [ltsc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output ltsc_pkg::chk_cfg_t                  chk_cfg
);

  logic [31:0] max_dist_r;
  logic [31:0] min_match_r;
  logic [31:0] max_match_r;
  logic [31:0] format_flags_r;
  logic [63:0] frame_size_r;
  logic [31:0] limit_distance_r;
  logic [31:0] limit_match_r;
  logic [63:0] limit_frame_r;

  ltsc_pkg::status_t param_status_r;
  ltsc_pkg::status_t param_status_nxt;
  logic              frame_over_r;
  logic              frame_over_nxt;

  logic [31:0] wdata32;

  assign wdata32 = cfg_wdata[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r       <= ltsc_pkg::RST_MAX_DIST;
      min_match_r      <= ltsc_pkg::RST_MIN_MATCH;
      max_match_r      <= ltsc_pkg::RST_MAX_MATCH;
      format_flags_r   <= ltsc_pkg::RST_FORMAT_FLAGS;
      frame_size_r     <= ltsc_pkg::RST_FRAME_SIZE;
      limit_distance_r <= ltsc_pkg::RST_LIMIT_DISTANCE;
      limit_match_r    <= ltsc_pkg::RST_LIMIT_MATCH;
      limit_frame_r    <= ltsc_pkg::RST_LIMIT_FRAME;
    end else if (cfg_we) begin
      unique case (ltsc_pkg::cfg_idx_t'(cfg_addr))
        ltsc_pkg::REG_MAX_DIST:       max_dist_r       <= wdata32;
        ltsc_pkg::REG_MIN_MATCH:      min_match_r      <= wdata32;
        ltsc_pkg::REG_MAX_MATCH:      max_match_r      <= wdata32;
        ltsc_pkg::REG_FORMAT_FLAGS:   format_flags_r   <= wdata32;
        ltsc_pkg::REG_FRAME_SIZE:     frame_size_r     <= cfg_wdata;
        ltsc_pkg::REG_LIMIT_DISTANCE: limit_distance_r <= wdata32;
        ltsc_pkg::REG_LIMIT_MATCH:    limit_match_r    <= wdata32;
        ltsc_pkg::REG_LIMIT_FRAME:    limit_frame_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (max_dist_r == 32'd0) begin
      param_status_nxt = ltsc_pkg::ST_WINDOW;
    end else if (min_match_r < ltsc_pkg::MIN_MATCH_FLOOR || max_match_r < min_match_r) begin
      param_status_nxt = ltsc_pkg::ST_RANGE;
    end else if (format_flags_r != 32'd0) begin
      param_status_nxt = ltsc_pkg::ST_FLAGS;
    end else if (max_dist_r > limit_distance_r || max_match_r > limit_match_r) begin
      param_status_nxt = ltsc_pkg::ST_LIMIT;
    end else begin
      param_status_nxt = ltsc_pkg::ST_OK;
    end
    frame_over_nxt = frame_size_r > limit_frame_r;
  end

  // precompute parameter checks; the user must change the registers only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      param_status_r <= ltsc_pkg::ST_OK;
      frame_over_r   <= 1'b0;
    end else begin
      param_status_r <= param_status_nxt;
      frame_over_r   <= frame_over_nxt;
    end
  end

  always_comb begin
    chk_cfg.max_dist     = max_dist_r;
    chk_cfg.min_match    = min_match_r;
    chk_cfg.max_match    = max_match_r;
    chk_cfg.limit_match  = limit_match_r;
    chk_cfg.frame_size   = frame_size_r;
    chk_cfg.param_status = param_status_r;
    chk_cfg.frame_over   = frame_over_r;
  end

endmodule

>>> rtl/core/ltsc_parse.sv
module ltsc_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  ltsc_pkg::in_item_t    item,
  input  ltsc_pkg::chk_cfg_t    chk_cfg,
  output logic                  res_valid,
  output ltsc_pkg::out_item_t   res
);

  logic [3:0]  pos_r, pos_nxt;
  logic        kind_r, kind_nxt;
  logic [31:0] dist_r, dist_nxt;
  logic [31:0] len_r, len_nxt;
  logic [63:0] count_r, count_nxt;

  logic [3:0]  pos_m1;
  logic [4:0]  shamt;
  logic [31:0] byte_shifted;
  logic [31:0] dist_asm;
  logic [31:0] len_asm;
  logic [3:0]  last_pos;
  logic [63:0] add_val;
  logic [64:0] sum;
  ltsc_pkg::status_t chk_status;

  assign pos_m1       = pos_r - ltsc_pkg::POS_FIRST;
  assign shamt        = {pos_m1[1:0], 3'b000};
  assign byte_shifted = 32'(item.in_byte) << shamt;

  always_comb begin
    dist_asm = dist_r;
    len_asm  = len_r;
    if (kind_r == ltsc_pkg::KIND_MATCH) begin
      if (pos_r <= ltsc_pkg::DIST_LAST) begin
        dist_asm = dist_r | byte_shifted;
      end else begin
        len_asm = len_r | byte_shifted;
      end
      last_pos = ltsc_pkg::MATCH_LAST;
    end else begin
      dist_asm = 32'(item.in_byte);
      last_pos = ltsc_pkg::LIT_LAST;
    end
  end

  assign add_val = (kind_r == ltsc_pkg::KIND_MATCH) ? 64'(len_asm) : 64'd1;
  assign sum     = {1'b0, count_r} + {1'b0, add_val};

  always_comb begin
    if (chk_cfg.param_status != ltsc_pkg::ST_OK) begin
      chk_status = chk_cfg.param_status;
    end else if (chk_cfg.frame_over || count_r > chk_cfg.frame_size) begin
      chk_status = ltsc_pkg::ST_LIMIT;
    end else if (kind_r == ltsc_pkg::KIND_MATCH && (dist_asm == 32'd0
                 || dist_asm > chk_cfg.max_dist || 64'(dist_asm) > count_r)) begin
      chk_status = ltsc_pkg::ST_DIST;
    end else if (kind_r == ltsc_pkg::KIND_MATCH && (len_asm < chk_cfg.min_match
                 || len_asm > chk_cfg.max_match || len_asm > chk_cfg.limit_match)) begin
      chk_status = ltsc_pkg::ST_LEN;
    end else if (sum[64]) begin
      chk_status = ltsc_pkg::ST_OVF;
    end else if (sum[63:0] > chk_cfg.frame_size) begin
      chk_status = ltsc_pkg::ST_MISMATCH;
    end else begin
      chk_status = ltsc_pkg::ST_OK;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    kind_nxt  = kind_r;
    dist_nxt  = dist_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    res_valid = 1'b0;
    res       = '0;
    res.status = ltsc_pkg::ST_OK;
    if (fire) begin
      if (pos_r == ltsc_pkg::POS_IDLE) begin
        if (item.in_byte > ltsc_pkg::TAG_MATCH) begin
          res_valid  = 1'b1;
          res.status = ltsc_pkg::ST_TAG;
        end else begin
          kind_nxt = item.in_byte[0];
          dist_nxt = 32'd0;
          len_nxt  = 32'd0;
          pos_nxt  = ltsc_pkg::POS_FIRST;
          if (item.frame_end) begin
            pos_nxt        = ltsc_pkg::POS_IDLE;
            res_valid      = 1'b1;
            res.token_kind = item.in_byte[0];
            res.status     = ltsc_pkg::ST_TRUNC;
          end
        end
      end else begin
        dist_nxt = dist_asm;
        len_nxt  = len_asm;
        if (pos_r < last_pos) begin
          pos_nxt = pos_r + 4'd1;
          if (item.frame_end) begin
            pos_nxt        = ltsc_pkg::POS_IDLE;
            res_valid      = 1'b1;
            res.token_kind = kind_r;
            res.status     = ltsc_pkg::ST_TRUNC;
          end
        end else begin
          pos_nxt        = ltsc_pkg::POS_IDLE;
          res_valid      = 1'b1;
          res.token_kind = kind_r;
          res.status     = chk_status;
          if (kind_r == ltsc_pkg::KIND_MATCH) begin
            res.match_distance = dist_asm;
            res.match_length   = len_asm;
          end else begin
            res.literal_byte = dist_asm[7:0];
          end
          if (chk_status == ltsc_pkg::ST_OK) begin
            res.produced_total = sum[63:0];
            count_nxt          = sum[63:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= ltsc_pkg::POS_IDLE;
      kind_r  <= ltsc_pkg::KIND_LIT;
      dist_r  <= 32'd0;
      len_r   <= 32'd0;
      count_r <= 64'd0;
    end else begin
      pos_r   <= pos_nxt;
      kind_r  <= kind_nxt;
      dist_r  <= dist_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

>>> rtl/core/lzss_token_stream_checker_unit.sv
// LZSS token stream checker: takes one stream byte per request and returns one
// result per completed token, unknown tag or truncated token. A byte is taken
// every cycle while results are drained; a result is offered once its last byte
// has passed the input register and the single-pass parse and check logic has
// loaded the result register, and a stalled result register holds the byte in
// the input register. Parameter checks are precomputed into a status register
// from the configuration registers after each write.
`include "lzss_token_stream_checker_unit_defines.svh"

module lzss_token_stream_checker_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ltsc_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ltsc_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [ltsc_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [ltsc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic                in_valid_r;
  ltsc_pkg::in_item_t  in_data_r;
  logic                out_valid_r;
  ltsc_pkg::out_item_t out_data_r;
  logic                fire;
  logic                res_valid;
  ltsc_pkg::out_item_t res;
  ltsc_pkg::chk_cfg_t  chk_cfg;

  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;

  ltsc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .chk_cfg   (chk_cfg)
  );

  ltsc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (in_data_r),
    .chk_cfg   (chk_cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LTSC_ASSERT_IMP(a_err_no_total, clk, rst_n,
    out_valid_r && out_data_r.status != ltsc_pkg::ST_OK, out_data_r.produced_total == 64'd0)
  `LTSC_ASSERT_IMP(a_tag_empty, clk, rst_n,
    out_valid_r && out_data_r.status == ltsc_pkg::ST_TAG,
    !out_data_r.token_kind && out_data_r.match_distance == 32'd0 && out_data_r.literal_byte == 8'd0)
  `LTSC_ASSERT_IMP(a_lit_fields, clk, rst_n,
    out_valid_r && !out_data_r.token_kind,
    out_data_r.match_distance == 32'd0 && out_data_r.match_length == 32'd0)
  `LTSC_ASSERT_NXT(a_stall_holds_input, clk, rst_n,
    in_valid_r && !fire, in_valid_r && $stable(in_data_r))

endmodule

>>> tb/sv/tb_lzss_token_stream_checker_unit.sv
module tb_lzss_token_stream_checker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 300000;

  localparam int unsigned RX_FREE    = 0;
  localparam int unsigned RX_MOSTLY  = 1;
  localparam int unsigned RX_COIN    = 2;
  localparam int unsigned RX_PATTERN = 3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  ltsc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ltsc_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [ltsc_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [ltsc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  lzss_token_stream_checker_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  logic [31:0] win_sz    = ltsc_pkg::RST_MAX_DIST;
  logic [31:0] min_len   = ltsc_pkg::RST_MIN_MATCH;
  logic [31:0] max_len   = ltsc_pkg::RST_MAX_MATCH;
  logic [31:0] flags_w   = ltsc_pkg::RST_FORMAT_FLAGS;
  logic [63:0] frame_sz  = ltsc_pkg::RST_FRAME_SIZE;
  logic [31:0] lim_dist  = ltsc_pkg::RST_LIMIT_DISTANCE;
  logic [31:0] lim_len   = ltsc_pkg::RST_LIMIT_MATCH;
  logic [63:0] lim_frame = ltsc_pkg::RST_LIMIT_FRAME;

  logic [3:0]  pos       = ltsc_pkg::POS_IDLE;
  logic        tok_kind  = ltsc_pkg::KIND_LIT;
  logic [31:0] dist_acc  = '0;
  logic [31:0] len_acc   = '0;
  logic [63:0] out_count = '0;

  ltsc_pkg::out_item_t due_verdicts[$];
  ltsc_pkg::out_item_t want;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycles = 0;

  bit idle_on = 1'b0;
  int unsigned gap_max = 1;
  int unsigned burst_left = 0;
  int unsigned rx_mode = RX_FREE;
  int unsigned rx_tick = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;

  function automatic ltsc_pkg::status_t param_status();
    if (win_sz == 0) return ltsc_pkg::ST_WINDOW;
    if (min_len < ltsc_pkg::MIN_MATCH_FLOOR || max_len < min_len) return ltsc_pkg::ST_RANGE;
    if (flags_w != 0) return ltsc_pkg::ST_FLAGS;
    if (win_sz > lim_dist || max_len > lim_len) return ltsc_pkg::ST_LIMIT;
    return ltsc_pkg::ST_OK;
  endfunction

  function automatic ltsc_pkg::status_t token_status(output logic [63:0] total);
    ltsc_pkg::status_t s;
    logic [63:0] add;
    logic [64:0] sum;
    total = '0;
    s = param_status();
    if (s != ltsc_pkg::ST_OK) return s;
    if (frame_sz > lim_frame || out_count > frame_sz) return ltsc_pkg::ST_LIMIT;
    if (tok_kind == ltsc_pkg::KIND_MATCH) begin
      if (dist_acc == 0 || dist_acc > win_sz || {32'd0, dist_acc} > out_count)
        return ltsc_pkg::ST_DIST;
      if (len_acc < min_len || len_acc > max_len || len_acc > lim_len)
        return ltsc_pkg::ST_LEN;
      add = {32'd0, len_acc};
    end else begin
      add = 64'd1;
    end
    sum = {1'b0, out_count} + {1'b0, add};
    if (sum[64]) return ltsc_pkg::ST_OVF;
    if (sum[63:0] > frame_sz) return ltsc_pkg::ST_MISMATCH;
    total = sum[63:0];
    return ltsc_pkg::ST_OK;
  endfunction

  function automatic bit parse_byte(input ltsc_pkg::in_item_t req,
                                    output ltsc_pkg::out_item_t r);
    logic [7:0] b;
    logic [3:0] last;
    int sh;
    ltsc_pkg::status_t s;
    logic [63:0] total;
    b = req.in_byte;
    r = '0;
    if (pos == ltsc_pkg::POS_IDLE) begin
      if (b > ltsc_pkg::TAG_MATCH) begin
        r.status = ltsc_pkg::ST_TAG;
        return 1'b1;
      end
      tok_kind = b[0];
      dist_acc = '0;
      len_acc = '0;
      pos = ltsc_pkg::POS_FIRST;
      if (req.frame_end) begin
        pos = ltsc_pkg::POS_IDLE;
        r.token_kind = tok_kind;
        r.status = ltsc_pkg::ST_TRUNC;
        return 1'b1;
      end
      return 1'b0;
    end
    if (tok_kind == ltsc_pkg::KIND_MATCH) begin
      if (pos <= ltsc_pkg::DIST_LAST) begin
        sh = 8 * ((int'(pos) - 1) % 4);
        dist_acc |= {24'd0, b} << sh;
      end else begin
        sh = 8 * ((int'(pos) - 5) % 4);
        len_acc |= {24'd0, b} << sh;
      end
      last = ltsc_pkg::MATCH_LAST;
    end else begin
      dist_acc = {24'd0, b};
      last = ltsc_pkg::LIT_LAST;
    end
    if (pos < last) begin
      pos++;
      if (req.frame_end) begin
        pos = ltsc_pkg::POS_IDLE;
        r.token_kind = tok_kind;
        r.status = ltsc_pkg::ST_TRUNC;
        return 1'b1;
      end
      return 1'b0;
    end
    pos = ltsc_pkg::POS_IDLE;
    s = token_status(total);
    if (s == ltsc_pkg::ST_OK) out_count = total;
    r.token_kind = tok_kind;
    r.status = s;
    r.produced_total = total;
    if (tok_kind == ltsc_pkg::KIND_MATCH) begin
      r.match_distance = dist_acc;
      r.match_length = len_acc;
    end else begin
      r.literal_byte = dist_acc[7:0];
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    mismatches++;
    $display("%0t ns %s: got %0h, expected %0h", $time, what, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (due_verdicts.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(out_data.status), 64'd0);
      end else begin
        want = due_verdicts.pop_front();
        if (out_data.token_kind !== want.token_kind)
          report_mismatch("token_kind", 64'(out_data.token_kind), 64'(want.token_kind));
        if (out_data.literal_byte !== want.literal_byte)
          report_mismatch("literal_byte", 64'(out_data.literal_byte),
                          64'(want.literal_byte));
        if (out_data.match_distance !== want.match_distance)
          report_mismatch("match_distance", 64'(out_data.match_distance),
                          64'(want.match_distance));
        if (out_data.match_length !== want.match_length)
          report_mismatch("match_length", 64'(out_data.match_length),
                          64'(want.match_length));
        if (out_data.status !== want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
        if (out_data.produced_total !== want.produced_total)
          report_mismatch("produced_total", out_data.produced_total, want.produced_total);
      end
    end
  end

  always @(posedge clk) begin
    rx_tick++;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:   out_ready <= 1'b1;
        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        RX_COIN:   out_ready <= ($urandom_range(0, 1) != 0);
        default:   out_ready <= ((rx_tick % 11) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** lzss_token_stream_checker_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fe);
    ltsc_pkg::in_item_t req;
    ltsc_pkg::out_item_t verdict;
    if (idle_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left != 0) burst_left--;
    req.in_byte = b;
    req.frame_end = fe;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (parse_byte(req, verdict)) due_verdicts.push_back(verdict);
  endtask

  task automatic send_lit(input logic [7:0] b, input logic fe_last);
    send_byte(8'd0, 1'b0);
    send_byte(b, fe_last);
  endtask

  // tag, distance LE, length LE; stop after nbytes, frame_end on the last one sent if fe_last
  task automatic send_match(input logic [31:0] d, input logic [31:0] l,
                            input int nbytes, input logic fe_last);
    logic [7:0] b;
    int k;
    for (k = 0; k < nbytes; k++) begin
      if (k == 0) b = ltsc_pkg::TAG_MATCH;
      else if (k <= 4) b = d[8*(k-1) +: 8];
      else b = l[8*(k-5) +: 8];
      send_byte(b, fe_last && (k == nbytes - 1));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input ltsc_pkg::cfg_idx_t idx, input logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      ltsc_pkg::REG_MAX_DIST:       win_sz = v[31:0];
      ltsc_pkg::REG_MIN_MATCH:      min_len = v[31:0];
      ltsc_pkg::REG_MAX_MATCH:      max_len = v[31:0];
      ltsc_pkg::REG_FORMAT_FLAGS:   flags_w = v[31:0];
      ltsc_pkg::REG_FRAME_SIZE:     frame_sz = v;
      ltsc_pkg::REG_LIMIT_DISTANCE: lim_dist = v[31:0];
      ltsc_pkg::REG_LIMIT_MATCH:    lim_len = v[31:0];
      ltsc_pkg::REG_LIMIT_FRAME:    lim_frame = v;
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
    repeat (3) @(posedge clk);
  endtask

  task automatic set_all(input logic [63:0] w, input logic [63:0] mn, input logic [63:0] mx,
                         input logic [63:0] fl, input logic [63:0] fs,
                         input logic [63:0] ld, input logic [63:0] lm,
                         input logic [63:0] lf);
    drain();
    write_reg(ltsc_pkg::REG_MAX_DIST, w);
    write_reg(ltsc_pkg::REG_MIN_MATCH, mn);
    write_reg(ltsc_pkg::REG_MAX_MATCH, mx);
    write_reg(ltsc_pkg::REG_FORMAT_FLAGS, fl);
    write_reg(ltsc_pkg::REG_FRAME_SIZE, fs);
    write_reg(ltsc_pkg::REG_LIMIT_DISTANCE, ld);
    write_reg(ltsc_pkg::REG_LIMIT_MATCH, lm);
    write_reg(ltsc_pkg::REG_LIMIT_FRAME, lf);
    cfg_done();
  endtask

  task automatic cfg_then_lit(input ltsc_pkg::cfg_idx_t idx, input logic [63:0] v,
                              input logic [7:0] b);
    drain();
    write_reg(idx, v);
    cfg_done();
    send_lit(b, 1'b0);
  endtask

  task automatic test_reset_values();
    idle_on = 1'b1;
    gap_max = 3;
    rx_mode = RX_MOSTLY;
    send_lit(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_match(32'd1, 32'd5, 9, 1'b0);
  endtask

  task automatic test_token_kinds();
    set_all(64'd4096, 64'd5, 64'd258, 64'd0, 64'd1_000_000, '1, '1, '1);
    send_lit(8'h00, 1'b0);
    send_lit(8'hFF, 1'b1);
    send_match(32'd2, 32'd5, 9, 1'b0);
    send_match(32'd0, 32'd5, 9, 1'b0);
    send_match(32'hFFFF_FFFF, 32'hFFFF_FFFF, 9, 1'b1);
    send_match(32'd1, 32'd4, 9, 1'b0);
    send_match(32'd1, 32'd259, 9, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b1);
    send_match(32'h0000_0101, 32'd0, 3, 1'b1);
    send_match(32'd7, 32'h0000_0105, 6, 1'b1);
  endtask

  task automatic test_output_hold();
    int i;
    drain();
    idle_on = 1'b0;
    rx_mode = RX_FREE;
    hold_req = 120;
    for (i = 0; i < 40; i++) send_lit(8'(i) ^ 8'hA5, 1'b0);
  endtask

  task automatic test_param_checks();
    idle_on = 1'b1;
    gap_max = 2;
    rx_mode = RX_PATTERN;
    cfg_then_lit(ltsc_pkg::REG_MAX_DIST, 64'd0, 8'h11);
    cfg_then_lit(ltsc_pkg::REG_MAX_DIST, 64'd4096, 8'h12);
    cfg_then_lit(ltsc_pkg::REG_MIN_MATCH, 64'd4, 8'h13);
    cfg_then_lit(ltsc_pkg::REG_MIN_MATCH, 64'd5, 8'h14);
    cfg_then_lit(ltsc_pkg::REG_MAX_MATCH, 64'd4, 8'h15);
    cfg_then_lit(ltsc_pkg::REG_MAX_MATCH, 64'd258, 8'h16);
    cfg_then_lit(ltsc_pkg::REG_FORMAT_FLAGS, 64'hFFFF_FFFF, 8'h17);
    cfg_then_lit(ltsc_pkg::REG_FORMAT_FLAGS, 64'd0, 8'h18);
    cfg_then_lit(ltsc_pkg::REG_LIMIT_DISTANCE, 64'd0, 8'h19);
    cfg_then_lit(ltsc_pkg::REG_LIMIT_DISTANCE, 64'd4096, 8'h1A);
    cfg_then_lit(ltsc_pkg::REG_LIMIT_MATCH, 64'd257, 8'h1B);
    cfg_then_lit(ltsc_pkg::REG_LIMIT_MATCH, 64'd258, 8'h1C);
    cfg_then_lit(ltsc_pkg::REG_LIMIT_FRAME, 64'd0, 8'h1D);
    cfg_then_lit(ltsc_pkg::REG_LIMIT_FRAME, '1, 8'h1E);
    cfg_then_lit(ltsc_pkg::REG_FRAME_SIZE, 64'd1, 8'h1F);
    cfg_then_lit(ltsc_pkg::REG_FRAME_SIZE, out_count, 8'h20);
    cfg_then_lit(ltsc_pkg::REG_FRAME_SIZE, out_count + 64'd1, 8'h21);
  endtask

  task automatic random_token();
    int pick;
    int nbytes;
    logic [31:0] d;
    logic [31:0] l;
    logic [63:0] lim;
    logic [63:0] span;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      send_byte(8'($urandom), $urandom_range(0, 9) == 0);
    end else if (pick < 55) begin
      send_lit(8'($urandom), $urandom_range(0, 19) == 0);
    end else begin
      if (out_count == 0 || $urandom_range(0, 4) == 0) begin
        d = ($urandom_range(0, 9) == 0) ? {32{$urandom_range(0, 1) == 1}} : $urandom;
      end else begin
        lim = (out_count < {32'd0, win_sz}) ? out_count : {32'd0, win_sz};
        if (lim == 0) lim = 64'd1;
        d = 32'd1 + 32'({$urandom, $urandom} % lim);
      end
      if (max_len >= min_len && $urandom_range(0, 4) != 0) begin
        span = {32'd0, max_len} - {32'd0, min_len} + 64'd1;
        l = min_len + 32'({$urandom, $urandom} % span);
      end else begin
        l = $urandom;
      end
      nbytes = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 8) : 9;
      send_match(d, l, nbytes, nbytes != 9 || $urandom_range(0, 19) == 0);
    end
  endtask

  task automatic test_random_streams();
    int ph;
    int unsigned stop_at;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          set_all(64'($urandom_range(32, 4096)), 64'($urandom_range(5, 8)), 64'd0, 64'd0,
                  out_count + 64'h100_0000_0000, '1, '1, '1);
          write_reg(ltsc_pkg::REG_MAX_MATCH, 64'(min_len + $urandom_range(0, 300)));
          cfg_done();
          idle_on = 1'b0;
          rx_mode = RX_FREE;
        end
        1: begin
          set_all(64'($urandom_range(1, 8)), 64'd5, 64'($urandom_range(5, 6)), 64'd0,
                  out_count + 64'd400, 64'd8, 64'd6, out_count + 64'd400);
          idle_on = 1'b1;
          gap_max = 4;
          rx_mode = RX_MOSTLY;
        end
        2: begin
          set_all('1, 64'd5, '1, 64'd0, '1, '1, '1, '1);
          idle_on = 1'b1;
          gap_max = 12;
          rx_mode = RX_PATTERN;
        end
        default: begin
          set_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0,
                  {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom});
          idle_on = 1'b1;
          gap_max = 3;
          rx_mode = RX_COIN;
        end
      endcase
      stop_at = bytes_sent + 100;
      while (bytes_sent < stop_at) random_token();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_token_kinds();
    test_output_hold();
    test_param_checks();
    test_random_streams();
    drain();
    if (mismatches == 0) begin
      $display("** lzss_token_stream_checker_unit: PASSED **");
    end else begin
      $display("** lzss_token_stream_checker_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ltsc_pkg.sv
rtl/core/ltsc_cfg.sv
rtl/core/ltsc_parse.sv
rtl/core/lzss_token_stream_checker_unit.sv
tb/sv/tb_lzss_token_stream_checker_unit.sv
